>>> hdl/assert_macros.svh
// Assertion helpers shared by the region hash change detector modules.
// Each macro expects signals named clock and reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RHCD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RHCD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/rhcd_pkg.sv
`timescale 1ns / 1ps
package rhcd_pkg;

   localparam int HASH_W   = 32;
   localparam int BYTE_W   = 8;
   localparam int COUNT_W  = 16;
   localparam int RCOUNT_W = 7;
   localparam int BAR_W    = 8;
   localparam int COL_W    = 9;
   // wide enough for region_count and any MAX_REGIONS up to 256
   localparam int CMP_W    = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;

   localparam logic [CSR_IDX_W-1:0] CSR_REGION_BYTES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BAR_START    = 2'd2;

   // Region close event handed from the scan stage to the result stage.
   typedef struct packed {
      logic              close;
      logic              last;
      logic [HASH_W-1:0] hash;
   } rhcd_close_type;

endpackage

>>> hdl/rhcd_ram.sv
`timescale 1ns / 1ps
module rhcd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/rhcd_scan.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rhcd_scan #(
   parameter int MAX_REGIONS = 64
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             fire,
   input  logic [rhcd_pkg::BYTE_W-1:0]                      data_byte,
   input  logic                                             scan_end,
   input  logic [rhcd_pkg::COUNT_W-1:0]                     region_bytes,
   input  logic [rhcd_pkg::RCOUNT_W-1:0]                    region_count,
   output rhcd_pkg::rhcd_close_type                         close_evt,
   output logic [(MAX_REGIONS > 1 ? $clog2(MAX_REGIONS) : 1)-1:0] slot
);
   import rhcd_pkg::*;

   localparam int IDX_W = $clog2(MAX_REGIONS + 1);
   localparam int AW    = MAX_REGIONS > 1 ? $clog2(MAX_REGIONS) : 1;

   logic [HASH_W-1:0]  hash_ff, hash_in, hash_step;
   logic [COUNT_W-1:0] count_ff, count_in, count_step, size;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [CMP_W-1:0]   count_req, max_cmp, eff_count;
   logic               active, closing;

   always_comb begin
      size      = (region_bytes == '0) ? COUNT_W'(1) : region_bytes;
      count_req = (region_count == '0) ? CMP_W'(1) : CMP_W'(region_count);
      max_cmp   = CMP_W'(MAX_REGIONS);
      eff_count = (count_req > max_cmp) ? max_cmp : count_req;
      active    = CMP_W'(idx_ff) < eff_count;

      // h * 33 is a shift and one add
      hash_step  = ((hash_ff << 5) + hash_ff) ^ HASH_W'(data_byte);
      count_step = count_ff + COUNT_W'(1);
      closing    = active && ((count_step >= size) || scan_end);

      hash_in  = hash_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      if (fire) begin
         priority if (scan_end) begin
            hash_in  = HASH_SEED;
            count_in = '0;
            idx_in   = '0;
         end else if (closing) begin
            hash_in  = HASH_SEED;
            count_in = '0;
            idx_in   = idx_ff + IDX_W'(1);
         end else if (active) begin
            hash_in  = hash_step;
            count_in = count_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff  <= HASH_SEED;
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         hash_ff  <= hash_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   assign close_evt.close = fire && closing;
   assign close_evt.last  = scan_end;
   assign close_evt.hash  = hash_step;
   assign slot            = idx_ff[AW-1:0];

   `RHCD_ASSERT_NEXT(a_scan_restart, fire && scan_end,
      idx_ff == '0 && count_ff == '0 && hash_ff == HASH_SEED,
      "scan state not restarted after scan end")
   `RHCD_ASSERT_NEXT(a_scan_hold, !fire,
      $stable(idx_ff) && $stable(count_ff) && $stable(hash_ff),
      "scan state moved without a transaction")

endmodule

>>> hdl/rhcd_result.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rhcd_result #(
   parameter int MAX_REGIONS = 64
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  rhcd_pkg::rhcd_close_type                         close_evt,
   input  logic [(MAX_REGIONS > 1 ? $clog2(MAX_REGIONS) : 1)-1:0] slot,
   input  logic [rhcd_pkg::BAR_W-1:0]                       bar_start,
   input  logic                                             rsp_ready,
   output logic                                             rsp_valid,
   output logic [rhcd_pkg::COL_W-1:0]                       rsp_column,
   output logic                                             rsp_changed,
   output logic                                             rsp_scan_done
);
   import rhcd_pkg::*;

   localparam int AW = MAX_REGIONS > 1 ? $clog2(MAX_REGIONS) : 1;

   logic                 valid_ff, valid_in;
   logic [AW-1:0]        slot_ff;
   logic [HASH_W-1:0]    hash_ff;
   logic                 last_ff;
   logic [COL_W-1:0]     column_ff;
   logic                 bypass_ff;
   logic [HASH_W-1:0]    bypass_hash_ff;
   logic                 prev_valid_ff;
   logic [MAX_REGIONS-1:0] written_ff;
   logic [HASH_W-1:0]    rd_data, prev_hash;
   logic                 rd_en, wr_en;

   assign rd_en = close_evt.close;
   assign wr_en = valid_ff && rsp_ready;

   // Stored hash table; the new hash is written back as the result leaves.
   rhcd_ram #(
      .WIDTH(HASH_W),
      .DEPTH(MAX_REGIONS)
   ) u_hash_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(slot_ff),
      .wr_data(hash_ff),
      .rd_en  (rd_en),
      .rd_addr(slot),
      .rd_data(rd_data)
   );

   always_comb begin
      valid_in = valid_ff;
      if (rd_en) begin
         valid_in = 1'b1;
      end else if (wr_en) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         written_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (wr_en) begin
            written_ff[slot_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         slot_ff        <= slot;
         hash_ff        <= close_evt.hash;
         last_ff        <= close_evt.last;
         column_ff      <= COL_W'(bar_start) + COL_W'(slot);
         // a write to the same entry in this cycle is not in the read data
         bypass_ff      <= wr_en && (slot_ff == slot);
         bypass_hash_ff <= hash_ff;
         prev_valid_ff  <= written_ff[slot];
      end
   end

   always_comb begin
      priority if (bypass_ff) begin
         prev_hash = bypass_hash_ff;
      end else if (prev_valid_ff) begin
         prev_hash = rd_data;
      end else begin
         prev_hash = '0;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_column    = column_ff;
   assign rsp_changed   = prev_hash != hash_ff;
   assign rsp_scan_done = last_ff;

   `RHCD_ASSERT_NEXT(a_close_loads, rd_en,
      valid_ff && last_ff == $past(close_evt.last) && slot_ff == $past(slot),
      "region close not loaded into the result register")
   `RHCD_ASSERT_SAME(a_load_needs_room, rd_en && valid_ff, rsp_ready,
      "region close overwrote a waiting result")

endmodule

>>> hdl/region_hash_change_detector_core.sv
`timescale 1ns / 1ps
// Region hash change detector: streams one memory byte per transaction, cuts
// the scan into regions of region_bytes bytes and hashes each with djb2 (xor
// form, seed 5381, times 33). When a region closes (byte count reached, or the
// byte carries scan_end) one result transaction reports the bar column
// (bar_start plus region index), whether the hash differs from the one stored
// for that region on the previous scan, and whether the scan ended. Bytes past
// the last region produce nothing. One byte is accepted every cycle; a result
// appears in the cycle after its closing byte and is held in the output register
// until taken, while the input stalls only if that register is full and not
// being drained. The stored hashes sit in a MAX_REGIONS-entry RAM with a
// per-entry written bit cleared at reset, so the first scan compares against
// zero and no clearing pass is needed. Configuration registers (index 0:
// region_bytes, 1: region_count, 2: bar_start) are written through the csr_
// channel, which is always ready.
module region_hash_change_detector_core #(
   parameter int MAX_REGIONS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   // byte stream
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [rhcd_pkg::BYTE_W-1:0]      req_data_byte,
   input  logic                             req_scan_end,
   // region results
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [rhcd_pkg::COL_W-1:0]       rsp_column,
   output logic                             rsp_changed,
   output logic                             rsp_scan_done,
   // configuration writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rhcd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rhcd_pkg::CSR_DATA_W-1:0]  csr_data
);
   import rhcd_pkg::*;

   localparam int AW = MAX_REGIONS > 1 ? $clog2(MAX_REGIONS) : 1;

   logic [COUNT_W-1:0]  region_bytes_ff;
   logic [RCOUNT_W-1:0] region_count_ff;
   logic [BAR_W-1:0]    bar_start_ff;
   logic                req_fire;
   rhcd_close_type      close_evt;
   logic [AW-1:0]       slot;

   // Configuration writes go straight into the registers; indexes past the list are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_bytes_ff <= COUNT_W'(1);
         region_count_ff <= RCOUNT_W'(64);
         bar_start_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_REGION_BYTES: region_bytes_ff <= csr_data;
            CSR_REGION_COUNT: region_count_ff <= csr_data[RCOUNT_W-1:0];
            CSR_BAR_START:    bar_start_ff    <= csr_data[BAR_W-1:0];
            default:          ;
         endcase
      end
   end

   // Advance the scan whenever the result register is free or draining, so a
   // closing byte always finds room for its result.
   assign req_ready = !rsp_valid || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // Hash, byte count and region index; flags a region close.
   rhcd_scan #(
      .MAX_REGIONS(MAX_REGIONS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .fire        (req_fire),
      .data_byte   (req_data_byte),
      .scan_end    (req_scan_end),
      .region_bytes(region_bytes_ff),
      .region_count(region_count_ff),
      .close_evt   (close_evt),
      .slot        (slot)
   );

   // Look up the previous hash, compare, hold the result, store the new hash.
   rhcd_result #(
      .MAX_REGIONS(MAX_REGIONS)
   ) u_result (
      .clock        (clock),
      .reset        (reset),
      .close_evt    (close_evt),
      .slot         (slot),
      .bar_start    (bar_start_ff),
      .rsp_ready    (rsp_ready),
      .rsp_valid    (rsp_valid),
      .rsp_column   (rsp_column),
      .rsp_changed  (rsp_changed),
      .rsp_scan_done(rsp_scan_done)
   );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import rhcd_pkg::*;

   localparam int CLOCK_PERIOD   = 20;
   localparam int NUM_REGIONS    = 64;
   localparam int RANDOM_ITEMS   = 1930;
   localparam int SETTLE_CYCLES  = 4;
   localparam int TIMEOUT_CYCLES = 500_000;
   localparam int IDLE_PERCENT   = 14;

   // index 3 decodes to no register; writes there must leave everything alone
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum logic {ROW_BYTE, ROW_WRITE} row_kind_type;
   typedef enum logic [1:0] {CHECK_MODEL, CHECK_TYPED, CHECK_SILENT} row_check_type;

   typedef struct packed {
      logic [COL_W-1:0] column;
      logic             changed;
      logic             scan_done;
   } region_result_type;

   // Byte rows carry CSR_REGION_BYTES in the unused index field.
   typedef struct packed {
      row_kind_type           kind;
      row_check_type          check;
      logic [CSR_IDX_W-1:0]   index;
      logic [CSR_DATA_W-1:0]  word;
      logic [BYTE_W-1:0]      data;
      logic                   scan_end;
      logic [COL_W-1:0]       column;
      logic                   changed;
      logic                   scan_done;
   } directed_row_type;

   localparam int NUM_DIRECTED = 31;
   localparam directed_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      // first scan after reset: every region compares against zero
      '{ROW_BYTE,  CHECK_TYPED,  CSR_REGION_BYTES, 16'h0000, 8'h00, 1'b0, 9'd0,   1'b1, 1'b0},
      '{ROW_BYTE,  CHECK_TYPED,  CSR_REGION_BYTES, 16'h0000, 8'hFF, 1'b0, 9'd1,   1'b1, 1'b0},
      '{ROW_BYTE,  CHECK_TYPED,  CSR_REGION_BYTES, 16'h0000, 8'h5A, 1'b1, 9'd2,   1'b1, 1'b1},
      // second scan: region 0 repeats, region 1 differs
      '{ROW_BYTE,  CHECK_TYPED,  CSR_REGION_BYTES, 16'h0000, 8'h00, 1'b0, 9'd0,   1'b0, 1'b0},
      '{ROW_BYTE,  CHECK_TYPED,  CSR_REGION_BYTES, 16'h0000, 8'h01, 1'b1, 9'd1,   1'b1, 1'b1},
      // zero size and zero count both act as one; bar at its top column
      '{ROW_WRITE, CHECK_MODEL,  CSR_BAR_START,    16'h00FF, 8'h00, 1'b0, 9'd0,   1'b0, 1'b0},
      '{ROW_WRITE, CHECK_MODEL,  CSR_REGION_BYTES, 16'h0000, 8'h00, 1'b0, 9'd0,   1'b0, 1'b0},
      '{ROW_WRITE, CHECK_MODEL,  CSR_REGION_COUNT, 16'h0000, 8'h00, 1'b0, 9'd0,   1'b0, 1'b0},
      '{ROW_BYTE,  CHECK_TYPED,  CSR_REGION_BYTES, 16'h0000, 8'h00, 1'b0, 9'd255, 1'b0, 1'b0},
      // past the last region: nothing, not even on scan_end
      '{ROW_BYTE,  CHECK_SILENT, CSR_REGION_BYTES, 16'h0000, 8'h77, 1'b0, 9'd0,   1'b0, 1'b0},
      '{ROW_BYTE,  CHECK_SILENT, CSR_REGION_BYTES, 16'h0000, 8'h33, 1'b1, 9'd0,   1'b0, 1'b0},
      // count above the region store saturates; short final region
      '{ROW_WRITE, CHECK_MODEL,  CSR_REGION_COUNT, 16'h007F, 8'h00, 1'b0, 9'd0,   1'b0, 1'b0},
      '{ROW_WRITE, CHECK_MODEL,  CSR_REGION_BYTES, 16'h0003, 8'h00, 1'b0, 9'd0,   1'b0, 1'b0},
      '{ROW_BYTE,  CHECK_MODEL,  CSR_REGION_BYTES, 16'h0000, 8'h10, 1'b0, 9'd0,   1'b0, 1'b0},
      '{ROW_BYTE,  CHECK_MODEL,  CSR_REGION_BYTES, 16'h0000, 8'h20, 1'b0, 9'd0,   1'b0, 1'b0},
      '{ROW_BYTE,  CHECK_MODEL,  CSR_REGION_BYTES, 16'h0000, 8'h30, 1'b0, 9'd0,   1'b0, 1'b0},
      '{ROW_BYTE,  CHECK_MODEL,  CSR_REGION_BYTES, 16'h0000, 8'hFF, 1'b1, 9'd0,   1'b0, 1'b0},
      // widest region, high data bits that the registers must drop
      '{ROW_WRITE, CHECK_MODEL,  CSR_REGION_BYTES, 16'hFFFF, 8'h00, 1'b0, 9'd0,   1'b0, 1'b0},
      '{ROW_WRITE, CHECK_MODEL,  CSR_REGION_COUNT, 16'hFF82, 8'h00, 1'b0, 9'd0,   1'b0, 1'b0},
      '{ROW_WRITE, CHECK_MODEL,  CSR_BAR_START,    16'hFF00, 8'h00, 1'b0, 9'd0,   1'b0, 1'b0},
      '{ROW_WRITE, CHECK_MODEL,  CSR_SPARE,        16'hFFFF, 8'h00, 1'b0, 9'd0,   1'b0, 1'b0},
      '{ROW_BYTE,  CHECK_MODEL,  CSR_REGION_BYTES, 16'h0000, 8'hAA, 1'b0, 9'd0,   1'b0, 1'b0},
      '{ROW_BYTE,  CHECK_MODEL,  CSR_REGION_BYTES, 16'h0000, 8'h55, 1'b0, 9'd0,   1'b0, 1'b0},
      '{ROW_BYTE,  CHECK_MODEL,  CSR_REGION_BYTES, 16'h0000, 8'h00, 1'b1, 9'd0,   1'b0, 1'b0},
      // shrink the region size in the middle of a scan
      '{ROW_WRITE, CHECK_MODEL,  CSR_REGION_BYTES, 16'h0002, 8'h00, 1'b0, 9'd0,   1'b0, 1'b0},
      '{ROW_BYTE,  CHECK_MODEL,  CSR_REGION_BYTES, 16'h0000, 8'h01, 1'b0, 9'd0,   1'b0, 1'b0},
      '{ROW_WRITE, CHECK_MODEL,  CSR_REGION_BYTES, 16'h0001, 8'h00, 1'b0, 9'd0,   1'b0, 1'b0},
      '{ROW_BYTE,  CHECK_MODEL,  CSR_REGION_BYTES, 16'h0000, 8'h02, 1'b0, 9'd0,   1'b0, 1'b0},
      '{ROW_BYTE,  CHECK_MODEL,  CSR_REGION_BYTES, 16'h0000, 8'h03, 1'b0, 9'd0,   1'b0, 1'b0},
      '{ROW_BYTE,  CHECK_MODEL,  CSR_REGION_BYTES, 16'h0000, 8'h04, 1'b0, 9'd0,   1'b0, 1'b0},
      '{ROW_BYTE,  CHECK_MODEL,  CSR_REGION_BYTES, 16'h0000, 8'h05, 1'b1, 9'd0,   1'b0, 1'b0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [BYTE_W-1:0]     req_data_byte = '0;
   logic                  req_scan_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [COL_W-1:0]      rsp_column;
   logic                  rsp_changed;
   logic                  rsp_scan_done;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Mirror of the block: configuration and scan state.
   logic [COUNT_W-1:0]    cfg_region_bytes = 16'd1;
   logic [RCOUNT_W-1:0]   cfg_region_count = 7'd64;
   logic [BAR_W-1:0]      cfg_bar_start = 8'd0;
   logic [HASH_W-1:0]     run_hash = HASH_SEED;
   logic [COUNT_W-1:0]    run_bytes = '0;
   logic [RCOUNT_W-1:0]   run_region = '0;
   logic [HASH_W-1:0]     stored_hash [NUM_REGIONS];

   region_result_type     pending_regions [$];
   region_result_type     oldest_region;
   logic [BYTE_W-1:0]     scan_image [256];

   bit                    no_idle = 1'b0;
   int                    failures = 0;
   int                    bytes_sent = 0;
   int                    regions_checked = 0;
   int                    regions_unchanged = 0;
   int                    writes_done = 0;

   region_hash_change_detector_core #(
      .MAX_REGIONS(NUM_REGIONS)
   ) DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data_byte(req_data_byte),
      .req_scan_end (req_scan_end),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_column   (rsp_column),
      .rsp_changed  (rsp_changed),
      .rsp_scan_done(rsp_scan_done),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Region size and count as the block applies them: zero acts as one, the
   // count saturates at the size of the hash store.
   function automatic int effective_bytes();
      return (cfg_region_bytes == '0) ? 1 : int'(cfg_region_bytes);
   endfunction

   function automatic int effective_regions();
      if (cfg_region_count == '0)
         return 1;
      if (int'(cfg_region_count) > NUM_REGIONS)
         return NUM_REGIONS;
      return int'(cfg_region_count);
   endfunction

   // Advance the hash mirror by one byte; return 1 when a region closes.
   function automatic bit hash_region_byte(input logic [BYTE_W-1:0] data,
                                           input logic last,
                                           output region_result_type closed);
      bit produced;
      produced = 1'b0;
      closed = '0;
      if (int'(run_region) < effective_regions()) begin
         run_hash = (run_hash * 32'd33) ^ {24'd0, data};
         run_bytes = run_bytes + 16'd1;
         if (int'(run_bytes) >= effective_bytes() || last) begin
            closed.column = {1'b0, cfg_bar_start} + {2'b00, run_region};
            closed.changed = (stored_hash[run_region[5:0]] != run_hash);
            closed.scan_done = last;
            stored_hash[run_region[5:0]] = run_hash;
            produced = 1'b1;
            run_hash = HASH_SEED;
            run_bytes = '0;
            run_region = run_region + 7'd1;
         end
      end
      // any scan_end restarts the scan, even on an ignored byte
      if (last) begin
         run_hash = HASH_SEED;
         run_bytes = '0;
         run_region = '0;
      end
      return produced;
   endfunction

   // Drop valid, wait for every outstanding region, then let the output
   // register drain before touching configuration.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_regions.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] word);
      settle();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= word;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_REGION_BYTES: cfg_region_bytes = word;
         CSR_REGION_COUNT: cfg_region_count = word[RCOUNT_W-1:0];
         CSR_BAR_START:    cfg_bar_start = word[BAR_W-1:0];
         default: ;
      endcase
      writes_done++;
      // drop valid between writes so back-to-back writes never collide
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one byte, hold it until the transaction completes, then update
   // the hash mirror. Valid stays high for the caller's next byte.
   task automatic send_byte(input logic [BYTE_W-1:0] data, input logic last,
                            output bit produced, output region_result_type closed);
      if (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_scan_end  <= last;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      produced = hash_region_byte(data, last, closed);
   endtask

   // Result side back-pressure; no stalls during the quiet stretch.
   always @(posedge clock)
      rsp_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);

   // Compare every result transaction with the oldest predicted region.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_regions.size() == 0) begin
            $error("unexpected result: column %0d changed %0d scan_done %0d",
                   rsp_column, rsp_changed, rsp_scan_done);
            failures++;
         end else begin
            oldest_region = pending_regions.pop_front();
            regions_checked++;
            if (!rsp_changed)
               regions_unchanged++;
            if (rsp_column !== oldest_region.column) begin
               $error("column: expected %0d, got %0d", oldest_region.column, rsp_column);
               failures++;
            end
            if (rsp_changed !== oldest_region.changed) begin
               $error("changed: expected %0d, got %0d", oldest_region.changed, rsp_changed);
               failures++;
            end
            if (rsp_scan_done !== oldest_region.scan_done) begin
               $error("scan_done: expected %0d, got %0d",
                      oldest_region.scan_done, rsp_scan_done);
               failures++;
            end
         end
      end
   end

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("timeout with %0d regions outstanding", pending_regions.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      directed_row_type    row;
      bit                  produced;
      region_result_type   closed;
      region_result_type   typed;
      int                  random_bytes;
      int                  full_span;
      int                  span;
      int                  scans;
      int                  pick;
      bit                  noisy;
      logic [CSR_DATA_W-1:0] word;
      logic [BYTE_W-1:0]   data;
      logic                last;

      random_bytes = 0;
      for (int k = 0; k < NUM_REGIONS; k++)
         stored_hash[k] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows: typed results where they are obvious, mirror otherwise.
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         row = DIRECTED_ROWS[i];
         if (row.kind == ROW_WRITE) begin
            write_register(row.index, row.word);
         end else begin
            send_byte(row.data, row.scan_end, produced, closed);
            case (row.check)
               CHECK_TYPED: begin
                  typed.column = row.column;
                  typed.changed = row.changed;
                  typed.scan_done = row.scan_end;
                  pending_regions.push_back(typed);
               end
               CHECK_MODEL: begin
                  if (produced)
                     pending_regions.push_back(closed);
               end
               default: ;
            endcase
         end
      end

      // Random phases: pick a setting, then replay a memory image over
      // several scans so that most regions repeat and a few change.
      while (random_bytes < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0:       word = 16'd0;
            1:       word = 16'hFFFF;
            2:       word = 16'($urandom_range(7, 40));
            default: word = 16'($urandom_range(1, 6));
         endcase
         write_register(CSR_REGION_BYTES, word);

         word = 16'($urandom);
         pick = $urandom_range(0, 9);
         case (pick)
            0:       word[RCOUNT_W-1:0] = 7'd0;
            1:       word[RCOUNT_W-1:0] = 7'($urandom_range(65, 127));
            2:       word[RCOUNT_W-1:0] = 7'd64;
            default: word[RCOUNT_W-1:0] = 7'($urandom_range(1, 16));
         endcase
         write_register(CSR_REGION_COUNT, word);

         word = 16'($urandom);
         if ($urandom_range(0, 4) == 0)
            word[BAR_W-1:0] = 8'hFF;
         write_register(CSR_BAR_START, word);
         if ($urandom_range(0, 7) == 0)
            write_register(CSR_SPARE, 16'($urandom));

         for (int j = 0; j < 256; j++)
            scan_image[j] = 8'($urandom);
         full_span = effective_bytes() * effective_regions();
         scans = $urandom_range(2, 6);

         repeat (scans) begin
            // mostly whole scans; wide regions always end early
            if (full_span > 160)
               span = $urandom_range(1, 160);
            else if ($urandom_range(0, 9) < 6)
               span = full_span;
            else
               span = $urandom_range(1, full_span + 6);
            noisy = ($urandom_range(0, 9) == 0);
            // stop at the byte budget even in the middle of a scan
            for (int j = 0; j < span && random_bytes < RANDOM_ITEMS; j++) begin
               data = scan_image[j];
               if ($urandom_range(0, 19) == 0)
                  data = 8'($urandom);
               last = (j == span - 1) || (noisy && $urandom_range(0, 19) == 0);
               no_idle = (random_bytes >= 700 && random_bytes < 1000);
               send_byte(data, last, produced, closed);
               if (produced)
                  pending_regions.push_back(closed);
               random_bytes++;
            end
         end
      end

      // Drain: bounded wait for the last results, then idle before the final check.
      req_valid <= 1'b0;
      no_idle = 1'b0;
      repeat (2000) begin
         if (pending_regions.size() != 0)
            @(posedge clock);
      end
      repeat (SETTLE_CYCLES * 2) @(posedge clock);
      if (pending_regions.size() != 0) begin
         $error("%0d predicted regions never arrived", pending_regions.size());
         failures++;
      end

      $display("run covered %0d bytes and %0d register writes", bytes_sent, writes_done);
      $display("checked %0d region results, %0d of them unchanged",
               regions_checked, regions_unchanged);
      if (failures == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
